### rtl/dagcau_pkg.sv
// Package with shared types, operation codes and a bit-reversal helper of the circular address update unit.
`default_nettype none

package dagcau_pkg;

    localparam int WORD_W = 32;
    localparam int KIND_W = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_CIRC_ADD = 2'd0;
    localparam t_kind KIND_CIRC_SUB = 2'd1;
    localparam t_kind KIND_BREV_ADD = 2'd2;

    function automatic t_word bit_reverse(input t_word value);
        t_word result;
        for (int k = 0; k < WORD_W; k++) begin
            result[k] = value[WORD_W-1-k];
        end
        return result;
    endfunction

endpackage

`default_nettype wire

### rtl/dagcau_update.sv
// Combinational pointer update for circular add, circular subtract and bit-reversed add.
`default_nettype none

module dagcau_update (
    input  wire dagcau_pkg::t_kind i_kind,
    input  wire dagcau_pkg::t_word i_index_ptr,
    input  wire dagcau_pkg::t_word i_buf_length,
    input  wire dagcau_pkg::t_word i_buf_base,
    input  wire dagcau_pkg::t_word i_modifier,
    output dagcau_pkg::t_word      o_new_index
);
    import dagcau_pkg::*;

    logic [WORD_W:0] add_sum;
    logic [WORD_W:0] sub_sum;
    logic [WORD_W:0] lb_sum;
    t_word           neg_mod;
    t_word           add_s32;
    t_word           sub_s32;
    t_word           lb32;
    t_word           add_wrapped;
    t_word           sub_wrapped;
    t_word           add_result;
    t_word           sub_result;
    t_word           brev_result;
    logic            add_lt_base;
    logic            add_lt_lb;
    logic            sub_lt_base;
    logic            sub_lt_lb;
    logic            sub_c1;

    assign add_sum = {1'b0, i_index_ptr} + {1'b0, i_modifier};
    assign neg_mod = ~i_modifier + t_word'(1);
    assign sub_sum = {1'b0, i_index_ptr} + {1'b0, neg_mod};
    assign lb_sum  = {1'b0, i_buf_length} + {1'b0, i_buf_base};

    assign add_s32 = add_sum[WORD_W-1:0];
    assign sub_s32 = sub_sum[WORD_W-1:0];
    assign lb32    = lb_sum[WORD_W-1:0];

    assign add_lt_base = add_s32 < i_buf_base;
    assign add_lt_lb   = add_s32 < lb32;
    assign sub_lt_base = sub_s32 < i_buf_base;
    assign sub_lt_lb   = sub_s32 < lb32;

    assign sub_c1 = i_index_ptr[WORD_W-1] & sub_sum[WORD_W];

    always_comb begin
        if (i_modifier[WORD_W-1]) begin
            add_wrapped = add_s32 + i_buf_length;
            if (i_index_ptr[WORD_W-1] || add_sum[WORD_W]) begin
                add_result = add_lt_base ? add_wrapped : add_s32;
            end else begin
                add_result = add_lt_base ? add_s32 : add_wrapped;
            end
        end else begin
            add_wrapped = add_s32 - i_buf_length;
            if (add_sum[WORD_W] == lb_sum[WORD_W]) begin
                add_result = add_lt_lb ? add_s32 : add_wrapped;
            end else begin
                add_result = add_lt_lb ? add_wrapped : add_s32;
            end
        end
    end

    always_comb begin
        if (i_modifier[WORD_W-1]) begin
            sub_wrapped = sub_s32 - i_buf_length;
            if (sub_c1 == lb_sum[WORD_W]) begin
                sub_result = sub_lt_lb ? sub_s32 : sub_wrapped;
            end else begin
                sub_result = sub_lt_lb ? sub_wrapped : sub_s32;
            end
        end else begin
            sub_wrapped = sub_s32 + i_buf_length;
            // A zero modifier behaves as if the sum had carried out.
            if ((i_modifier == '0) || sub_sum[WORD_W]) begin
                sub_result = sub_lt_base ? sub_wrapped : sub_s32;
            end else begin
                sub_result = sub_lt_base ? sub_s32 : sub_wrapped;
            end
        end
    end

    assign brev_result = bit_reverse(bit_reverse(i_index_ptr) + bit_reverse(i_modifier));

    always_comb begin
        unique case (i_kind)
            KIND_CIRC_ADD: o_new_index = add_result;
            KIND_CIRC_SUB: o_new_index = sub_result;
            KIND_BREV_ADD: o_new_index = brev_result;
            default:       o_new_index = i_index_ptr;
        endcase
    end

endmodule

`default_nettype wire

### rtl/dag_circular_address_update.sv
// Top level of the circular and bit-reversed address update unit.
// A transaction is offered by raising start with the operation kind, the index
// pointer, the buffer length, the buffer base and the modifier on their ports.
// It is taken at the rising edge where start is high and busy is low; busy is
// always low, so a new transaction can be taken on every clock cycle.
// The operands go into an input register, one pass of combinational logic
// computes the new pointer, and the result register drives o_new_index with
// o_valid high for exactly one cycle.
// Throughput is one transaction per cycle, with a single combinational pass of
// adders and compares between the two registers.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// A synchronous active-low reset clears both valid flags, so no result is
// shown after reset until a new transaction has been taken. The operand and
// result data registers are not reset.
`default_nettype none

module dag_circular_address_update (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire dagcau_pkg::t_kind i_kind,
    input  wire dagcau_pkg::t_word i_index_ptr,
    input  wire dagcau_pkg::t_word i_buf_length,
    input  wire dagcau_pkg::t_word i_buf_base,
    input  wire dagcau_pkg::t_word i_modifier,
    output logic                   o_valid,
    output dagcau_pkg::t_word      o_new_index
);
    import dagcau_pkg::*;

    logic  r_in_valid;
    t_kind r_kind;
    t_word r_index_ptr;
    t_word r_buf_length;
    t_word r_buf_base;
    t_word r_modifier;
    logic  r_out_valid;
    t_word r_new_index;
    t_word n_new_index;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_kind       <= i_kind;
            r_index_ptr  <= i_index_ptr;
            r_buf_length <= i_buf_length;
            r_buf_base   <= i_buf_base;
            r_modifier   <= i_modifier;
        end
        if (r_in_valid) begin
            r_new_index <= n_new_index;
        end
    end

    dagcau_update u_update (
        .i_kind       (r_kind),
        .i_index_ptr  (r_index_ptr),
        .i_buf_length (r_buf_length),
        .i_buf_base   (r_buf_base),
        .i_modifier   (r_modifier),
        .o_new_index  (n_new_index)
    );

    assign o_valid     = r_out_valid;
    assign o_new_index = r_new_index;

endmodule

`default_nettype wire

### tb/tb_dag_circular_address_update.sv
// Self-checking testbench for the circular and bit-reversed address update unit.
`timescale 1ns / 100ps

module tb_dag_circular_address_update;
    import dagcau_pkg::*;

    localparam t_kind KIND_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_DIRECTED = 22;

    typedef struct packed {
        t_kind kind;
        t_word ptr;
        t_word len;
        t_word base;
        t_word mod;
        logic  typed;
        t_word want;
    } t_dir_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_kind i_kind = KIND_CIRC_ADD;
    t_word i_index_ptr = '0;
    t_word i_buf_length = '0;
    t_word i_buf_base = '0;
    t_word i_modifier = '0;
    logic  o_valid;
    t_word o_new_index;

    t_word pending_index_q[$];
    int    error_count = 0;
    int    result_count = 0;
    int    txn_count = 0;
    int    cycle_count = 0;
    int    kind_count[4] = '{0, 0, 0, 0};
    bit    no_idle = 1'b0;

    t_dir_row directed_rows [NUM_DIRECTED] = '{
        '{KIND_CIRC_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0},
        '{KIND_CIRC_ADD, 32'd1050, 32'd100, 32'd1000, 32'd60, 1'b1, 32'd1010},
        '{KIND_CIRC_SUB, 32'd1010, 32'd100, 32'd1000, 32'd60, 1'b1, 32'd1050},
        '{KIND_CIRC_ADD, 32'd1020, 32'd100, 32'd1000, 32'hFFFFFFE2, 1'b0, 32'd0},
        '{KIND_CIRC_SUB, 32'd1090, 32'd100, 32'd1000, 32'hFFFFFFE2, 1'b0, 32'd0},
        '{KIND_CIRC_SUB, 32'd1050, 32'd100, 32'd1000, 32'd0, 1'b0, 32'd0},
        '{KIND_CIRC_SUB, 32'd500, 32'd100, 32'd1000, 32'd0, 1'b0, 32'd0},
        '{KIND_CIRC_ADD, 32'd1000, 32'd0, 32'd1000, 32'd4, 1'b0, 32'd0},
        '{KIND_CIRC_ADD, 32'd5000, 32'd100, 32'd1000, 32'd8, 1'b0, 32'd0},
        '{KIND_CIRC_ADD, 32'd1000, 32'd16, 32'd1000, 32'd40, 1'b0, 32'd0},
        '{KIND_CIRC_ADD, 32'hFFFFFFF0, 32'd200, 32'hFFFFFF00, 32'd20, 1'b0, 32'd0},
        '{KIND_CIRC_SUB, 32'h00000010, 32'd200, 32'hFFFFFF00, 32'd40, 1'b0, 32'd0},
        '{KIND_CIRC_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          1'b0, 32'd0},
        '{KIND_CIRC_SUB, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          1'b0, 32'd0},
        '{KIND_CIRC_SUB, 32'h80000000, 32'd0, 32'd0, 32'h80000000, 1'b0, 32'd0},
        '{KIND_CIRC_ADD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'h7FFFFFFF, 1'b0, 32'd0},
        '{KIND_BREV_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0},
        '{KIND_BREV_ADD, 32'hFFFFFFFF, 32'd0, 32'd0, 32'hFFFFFFFF, 1'b0, 32'd0},
        '{KIND_BREV_ADD, 32'hFFFFFFFF, 32'd0, 32'd0, 32'h00000001, 1'b0, 32'd0},
        '{KIND_BREV_ADD, 32'd0, 32'd0, 32'd0, 32'h80000000, 1'b1, 32'h80000000},
        '{KIND_NONE, 32'hDEADBEEF, 32'd100, 32'd1000, 32'd60, 1'b1, 32'hDEADBEEF},
        '{KIND_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          1'b1, 32'hFFFFFFFF}
    };

    dag_circular_address_update u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_index_ptr  (i_index_ptr),
        .i_buf_length (i_buf_length),
        .i_buf_base   (i_buf_base),
        .i_modifier   (i_modifier),
        .o_valid      (o_valid),
        .o_new_index  (o_new_index)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_word circ_add_next(t_word ptr, t_word len, t_word base, t_word mod);
        logic [WORD_W:0] sum;
        logic [WORD_W:0] top;
        t_word           low;
        t_word           wrapped;
        sum = {1'b0, ptr} + {1'b0, mod};
        top = {1'b0, len} + {1'b0, base};
        low = sum[WORD_W-1:0];
        if (mod[WORD_W-1]) begin
            wrapped = ptr + mod + len;
            if (ptr[WORD_W-1] || sum[WORD_W])
                return (low < base) ? wrapped : low;
            return (low < base) ? low : wrapped;
        end
        wrapped = ptr + mod - len;
        if (sum[WORD_W] == top[WORD_W])
            return (low < top[WORD_W-1:0]) ? low : wrapped;
        return (low < top[WORD_W-1:0]) ? wrapped : low;
    endfunction

    function automatic t_word circ_sub_next(t_word ptr, t_word len, t_word base, t_word mod);
        t_word           neg;
        logic [WORD_W:0] sum;
        logic [WORD_W:0] top;
        t_word           low;
        t_word           wrapped;
        logic            ptr_carry;
        neg = ~mod + 1'b1;
        sum = {1'b0, ptr} + {1'b0, neg};
        top = {1'b0, len} + {1'b0, base};
        low = sum[WORD_W-1:0];
        if (mod[WORD_W-1]) begin
            ptr_carry = ptr[WORD_W-1] && sum[WORD_W];
            wrapped = ptr + neg - len;
            if (ptr_carry == top[WORD_W])
                return (low < top[WORD_W-1:0]) ? low : wrapped;
            return (low < top[WORD_W-1:0]) ? wrapped : low;
        end
        wrapped = ptr + neg + len;
        if (mod == '0 || sum[WORD_W])
            return (low < base) ? wrapped : low;
        return (low < base) ? low : wrapped;
    endfunction

    function automatic t_word brev_add_next(t_word ptr, t_word mod);
        logic       carry;
        logic [1:0] bit_sum;
        t_word      res;
        carry = 1'b0;
        res = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            bit_sum = ptr[k] + mod[k] + carry;
            res[k] = bit_sum[0];
            carry = bit_sum[1];
        end
        return res;
    endfunction

    function automatic t_word predict_new_index(t_kind kind, t_word ptr, t_word len,
                                                t_word base, t_word mod);
        case (kind)
            KIND_CIRC_ADD: return circ_add_next(ptr, len, base, mod);
            KIND_CIRC_SUB: return circ_sub_next(ptr, len, base, mod);
            KIND_BREV_ADD: return brev_add_next(ptr, mod);
            default:       return ptr;
        endcase
    endfunction

    function automatic t_word pick_edge_word();
        case ($urandom_range(0, 7))
            0:       return 32'h00000000;
            1:       return 32'h00000001;
            2:       return 32'h7FFFFFFF;
            3:       return 32'h80000000;
            4:       return 32'h80000001;
            5:       return 32'hFFFFFFFF;
            6:       return 32'hFFFFFFFE;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_txn(input t_kind kind, input t_word ptr, input t_word len,
                            input t_word base, input t_word mod, input logic typed,
                            input t_word want);
        i_kind <= kind;
        i_index_ptr <= ptr;
        i_buf_length <= len;
        i_buf_base <= base;
        i_modifier <= mod;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_index_q.push_back(typed ? want : predict_new_index(kind, ptr, len, base, mod));
        kind_count[kind]++;
        txn_count++;
    endtask

    task automatic idle_gap();
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_txn();
        t_kind kind;
        t_word ptr;
        t_word len;
        t_word base;
        t_word mod;
        int    sel;
        int    pick;
        pick = $urandom_range(0, 9);
        kind = (pick < 3) ? KIND_CIRC_ADD : (pick < 6) ? KIND_CIRC_SUB :
               (pick < 9) ? KIND_BREV_ADD : KIND_NONE;
        sel = $urandom_range(0, 7);
        if (sel < 4) begin
            base = $urandom;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32'h00100000)
                                               : $urandom_range(1, 256);
            ptr = base + $urandom_range(0, len - 1);
            mod = $urandom_range(0, len);
            if ($urandom_range(0, 1))
                mod = ~mod + 1'b1;
            if (kind == KIND_BREV_ADD) begin
                mod = 32'h1 << $urandom_range(0, 31);
                ptr = $urandom;
            end
        end else if (sel < 6) begin
            ptr = pick_edge_word();
            len = pick_edge_word();
            base = pick_edge_word();
            mod = pick_edge_word();
        end else begin
            ptr = $urandom;
            len = $urandom;
            base = $urandom;
            mod = $urandom;
        end
        send_txn(kind, ptr, len, base, mod, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_dag_circular_address_update: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            result_count++;
            if (pending_index_q.size() == 0) begin
                $error("unexpected result: new_index actual %h", o_new_index);
                error_count++;
            end else if (o_new_index !== pending_index_q[0]) begin
                $error("new_index mismatch: expected %h, actual %h",
                       pending_index_q[0], o_new_index);
                error_count++;
                void'(pending_index_q.pop_front());
            end else begin
                void'(pending_index_q.pop_front());
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[r]) begin
            idle_gap();
            send_txn(directed_rows[r].kind, directed_rows[r].ptr, directed_rows[r].len,
                     directed_rows[r].base, directed_rows[r].mod, directed_rows[r].typed,
                     directed_rows[r].want);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            idle_gap();
            random_txn();
        end
        start <= 1'b0;
        while (pending_index_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        error_count += pending_index_q.size();
        $display("Run covered %0d transactions (%0d table rows) and checked %0d results.",
                 txn_count, NUM_DIRECTED, result_count);
        $display("Per kind, add/sub/bit-reversed/no-op: %0d/%0d/%0d/%0d.",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        if (error_count == 0) begin
            $display("tb_dag_circular_address_update: done, clean");
        end else begin
            $display("tb_dag_circular_address_update: done, errors");
        end
        $finish;
    end

endmodule

### dag_circular_address_update.f
rtl/dagcau_pkg.sv
rtl/dagcau_update.sv
rtl/dag_circular_address_update.sv
tb/tb_dag_circular_address_update.sv
